### hw/rtl/assert_macros.svh
// Assertion macros used by the mark table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define NPMT_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("npmt implication check failed");

// Condition that must hold at every rising clock edge outside reset
`define NPMT_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("npmt invariant check failed");

`endif

### hw/rtl/npmt_pkg.sv
// Types, constants and helpers for the named position mark table
package npmt_pkg;

   localparam int OP_WIDTH   = 3;
   localparam int NAME_WIDTH = 8;
   localparam int LINE_WIDTH = 32;
   localparam int COL_WIDTH  = 16;
   localparam int IDX_WIDTH  = 6;

   localparam logic [NAME_WIDTH-1:0] NAME_QUOTE     = 8'd39;
   localparam logic [NAME_WIDTH-1:0] NAME_BACKQUOTE = 8'd96;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_SET_MARK   = 3'd0,
      OP_SET_PREV   = 3'd1,
      OP_GET        = 3'd2,
      OP_CLEAR_ALL  = 3'd3,
      OP_CLEAR_LINE = 3'd4
   } op_type;

   // token walking the cell row
   typedef struct packed {
      logic                  valid;
      op_type                op;
      logic [NAME_WIDTH-1:0] name;
      logic [LINE_WIDTH-1:0] line;
      logic [COL_WIDTH-1:0]  col;
      logic                  found;
      logic [LINE_WIDTH-1:0] hit_line;
      logic [COL_WIDTH-1:0]  hit_col;
      logic                  free_found;
      logic [IDX_WIDTH-1:0]  free_idx;
   } token_type;

   // write of a new letter into the lowest free cell
   typedef struct packed {
      logic                  en;
      logic [IDX_WIDTH-1:0]  idx;
      logic [NAME_WIDTH-1:0] name;
      logic [LINE_WIDTH-1:0] line;
      logic [COL_WIDTH-1:0]  col;
   } commit_type;

   typedef struct packed {
      logic                  success;
      logic [LINE_WIDTH-1:0] mark_line;
      logic [COL_WIDTH-1:0]  mark_column;
   } result_type;

   function automatic logic is_letter(input logic [NAME_WIDTH-1:0] c);
      logic upper;
      logic lower;
      upper = (c >= 8'd65) && (c <= 8'd90);
      lower = (c >= 8'd97) && (c <= 8'd122);
      return upper || lower;
   endfunction

endpackage

### hw/rtl/npmt_if.sv
// Request and response channel interfaces of the mark table
interface npmt_req_if;
   logic                             valid;
   logic                             ready;
   logic [npmt_pkg::OP_WIDTH-1:0]    operation;
   logic [npmt_pkg::NAME_WIDTH-1:0]  mark_name;
   logic [npmt_pkg::LINE_WIDTH-1:0]  line_ref;
   logic [npmt_pkg::COL_WIDTH-1:0]   column;

   modport source (output valid, operation, mark_name, line_ref, column, input ready);
   modport sink   (input valid, operation, mark_name, line_ref, column, output ready);
endinterface

interface npmt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             success;
   logic [npmt_pkg::LINE_WIDTH-1:0]  mark_line;
   logic [npmt_pkg::COL_WIDTH-1:0]   mark_column;

   modport source (output valid, success, mark_line, mark_column, input ready);
   modport sink   (input valid, success, mark_line, mark_column, output ready);
endinterface

### hw/rtl/npmt_cell.sv
// One mark slot of the table, acting on the token as it passes
module npmt_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [npmt_pkg::IDX_WIDTH-1:0]   cell_index,
   input  npmt_pkg::token_type              up_tok,
   input  npmt_pkg::commit_type             commit,
   output npmt_pkg::token_type              down_tok
);

   logic                              used_ff, used_in;
   logic [npmt_pkg::NAME_WIDTH-1:0]   letter_ff, letter_in;
   logic [npmt_pkg::LINE_WIDTH-1:0]   line_ff, line_in;
   logic [npmt_pkg::COL_WIDTH-1:0]    col_ff, col_in;
   npmt_pkg::token_type               tok_ff, tok_in;
   logic                              hit;

   always_comb begin
      hit       = used_ff && (letter_ff == up_tok.name);
      used_in   = used_ff;
      letter_in = letter_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      tok_in    = up_tok;
      if (commit.en && (commit.idx == cell_index)) begin
         used_in   = 1'b1;
         letter_in = commit.name;
         line_in   = commit.line;
         col_in    = commit.col;
      end
      if (up_tok.valid) begin
         case (up_tok.op)
            npmt_pkg::OP_SET_MARK: begin
               if (npmt_pkg::is_letter(up_tok.name)) begin
                  if (hit) begin
                     line_in      = up_tok.line;
                     col_in       = up_tok.col;
                     tok_in.found = 1'b1;
                  end
                  if (!used_ff && !up_tok.free_found) begin
                     tok_in.free_found = 1'b1;
                     tok_in.free_idx   = cell_index;
                  end
               end
            end
            npmt_pkg::OP_GET: begin
               if (hit) begin
                  tok_in.found    = 1'b1;
                  tok_in.hit_line = line_ff;
                  tok_in.hit_col  = col_ff;
               end
            end
            npmt_pkg::OP_CLEAR_ALL: begin
               used_in = 1'b0;
            end
            npmt_pkg::OP_CLEAR_LINE: begin
               if (used_ff && (line_ff == up_tok.line)) begin
                  used_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      letter_ff <= letter_in;
      line_ff   <= line_in;
      col_ff    <= col_in;
      if (reset) begin
         used_ff <= 1'b0;
         tok_ff  <= '0;
      end else begin
         used_ff <= used_in;
         tok_ff  <= tok_in;
      end
   end

   assign down_tok = tok_ff;

endmodule

### hw/rtl/named_position_mark_table.sv
// A request's token walks the cell row one cell a cycle, then the finishing step
//   settles the new-slot write and previous mark and registers the response.
// No new request is taken while a token is in the cell row (busy).
// A response waiting on the output does not stop the next request; a second one waits.
// Reset (synchronous): frees all slots and the previous mark, drops in-flight work
//   and pending responses; no clearing pass.
module named_position_mark_table #(
   parameter int NUM_SLOTS = 10
) (
   input  logic             clock,
   input  logic             reset,
   npmt_req_if.sink         req_chan,
   npmt_rsp_if.source       rsp_chan
);

   `include "assert_macros.svh"

   npmt_pkg::token_type                link [NUM_SLOTS+1];
   npmt_pkg::token_type                last;
   npmt_pkg::commit_type               commit;
   npmt_pkg::result_type               res;
   npmt_pkg::result_type               rsp_ff, rsp_in;
   npmt_pkg::result_type               hold_ff, hold_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               hold_valid_ff, hold_valid_in;
   logic                               busy_ff, busy_in;
   logic [npmt_pkg::LINE_WIDTH-1:0]    prev_line_ff, prev_line_in;
   logic [npmt_pkg::COL_WIDTH-1:0]     prev_col_ff, prev_col_in;
   logic                               prev_valid_ff, prev_valid_in;
   logic                               accept;
   logic                               rsp_take;
   logic [NUM_SLOTS-1:0]               tok_valid;

   assign req_chan.ready = !busy_ff && !hold_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_valid_ff && rsp_chan.ready;

   always_comb begin
      link[0]            = '0;
      link[0].valid      = accept;
      link[0].op         = npmt_pkg::op_type'(req_chan.operation);
      link[0].name       = req_chan.mark_name;
      link[0].line       = req_chan.line_ref;
      link[0].col        = req_chan.column;
   end

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      npmt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (npmt_pkg::IDX_WIDTH'(i)),
         .up_tok     (link[i]),
         .commit     (commit),
         .down_tok   (link[i+1])
      );
      assign tok_valid[i] = link[i+1].valid;
   end

   assign last = link[NUM_SLOTS];

   // finishing step: new-slot write, previous mark, result
   always_comb begin
      commit        = '0;
      res           = '0;
      prev_line_in  = prev_line_ff;
      prev_col_in   = prev_col_ff;
      prev_valid_in = prev_valid_ff;
      commit.name   = last.name;
      commit.line   = last.line;
      commit.col    = last.col;
      commit.idx    = last.free_idx;
      if (last.valid) begin
         case (last.op)
            npmt_pkg::OP_SET_MARK: begin
               if (npmt_pkg::is_letter(last.name)) begin
                  if (last.found) begin
                     res.success = 1'b1;
                  end else if (last.free_found) begin
                     res.success = 1'b1;
                     commit.en   = 1'b1;
                  end
               end
            end
            npmt_pkg::OP_SET_PREV: begin
               prev_line_in  = last.line;
               prev_col_in   = last.col;
               prev_valid_in = 1'b1;
               res.success   = 1'b1;
            end
            npmt_pkg::OP_GET: begin
               if ((last.name == npmt_pkg::NAME_QUOTE) ||
                   (last.name == npmt_pkg::NAME_BACKQUOTE)) begin
                  if (prev_valid_ff) begin
                     res.success     = 1'b1;
                     res.mark_line   = prev_line_ff;
                     res.mark_column = prev_col_ff;
                  end
               end else if (last.found) begin
                  res.success     = 1'b1;
                  res.mark_line   = last.hit_line;
                  res.mark_column = last.hit_col;
               end
            end
            npmt_pkg::OP_CLEAR_ALL: begin
               prev_valid_in = 1'b0;
            end
            npmt_pkg::OP_CLEAR_LINE: begin
               if (prev_valid_ff && (prev_line_ff == last.line)) begin
                  prev_valid_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // output register plus one skid entry
   always_comb begin
      rsp_in        = rsp_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff;
      hold_valid_in = hold_valid_ff;
      if (last.valid) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
         end else begin
            hold_in       = res;
            hold_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         if (hold_valid_ff) begin
            rsp_in        = hold_ff;
            hold_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (last.valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      hold_ff      <= hold_in;
      prev_line_ff <= prev_line_in;
      prev_col_ff  <= prev_col_in;
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         busy_ff       <= 1'b0;
         prev_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
         busy_ff       <= busy_in;
         prev_valid_ff <= prev_valid_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.success     = rsp_ff.success;
   assign rsp_chan.mark_line   = rsp_ff.mark_line;
   assign rsp_chan.mark_column = rsp_ff.mark_column;

   `NPMT_ASSERT_ALWAYS(a_one_token, $onehot0(tok_valid))
   `NPMT_ASSERT_IMPLIES(a_token_busy, |tok_valid, busy_ff)
   `NPMT_ASSERT_IMPLIES(a_skid_order, hold_valid_ff, rsp_valid_ff)
   `NPMT_ASSERT_IMPLIES(a_commit_new, commit.en, last.op == npmt_pkg::OP_SET_MARK && !last.found)
   `NPMT_ASSERT_IMPLIES(a_busy_done, last.valid, ##1 !busy_ff)

endmodule
